// ===== rtl/vfv_pkg.sv =====
// Shared types, codes and helpers for the voxel face visibility block.
package vfv_pkg;

  localparam int EDGE_DEFAULT = 16;
  localparam int COORD_W      = 4;
  localparam int SIDE_W       = 3;
  localparam int SIDE_COUNT   = 6;
  localparam int MASK_W       = 6;
  localparam int COUNT_W      = 3;
  localparam int TOTAL_W      = 15;
  localparam int STEP_W       = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  // Item operations.
  localparam logic [1:0] OP_LOAD_CELL   = 2'd0;
  localparam logic [1:0] OP_LOAD_PLANE  = 2'd1;
  localparam logic [1:0] OP_CLASSIFY    = 2'd2;
  localparam logic [1:0] OP_CLEAR_TOTAL = 2'd3;

  // Normal directions, also the side codes of the neighbour planes.
  localparam logic [SIDE_W-1:0] DIR_PZ = 3'd0;
  localparam logic [SIDE_W-1:0] DIR_NZ = 3'd1;
  localparam logic [SIDE_W-1:0] DIR_PY = 3'd2;
  localparam logic [SIDE_W-1:0] DIR_NY = 3'd3;
  localparam logic [SIDE_W-1:0] DIR_PX = 3'd4;
  localparam logic [SIDE_W-1:0] DIR_NX = 3'd5;

  // Where the neighbour of a face is looked up.
  localparam logic [1:0] SRC_NONE  = 2'd0;
  localparam logic [1:0] SRC_CHUNK = 2'd1;
  localparam logic [1:0] SRC_PLANE = 2'd2;

  // Scan step 0 reads the cell itself, steps 1 to 6 read its neighbours.
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

  typedef struct packed {
    logic              sweep;
    logic              capture;
    logic              write;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              emit;
  } vfv_cmd_t;

  typedef struct packed {
    logic sweep_done;
    logic classify_inside;
    logic emit_ok;
  } vfv_stat_t;

  function automatic logic [COUNT_W-1:0] count_faces(input logic [MASK_W-1:0] mask);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MASK_W; i++) begin
      n = n + COUNT_W'(mask[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/vfv_ctrl.sv =====
// Controller state machine: clearing pass, item intake, neighbour scan and result hand-off.
module vfv_ctrl
  import vfv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  vfv_stat_t stat,
  output vfv_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state;
  logic [2:0]        state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.classify_inside) begin
          step_next  = '0;
          state_next = S_SCAN;
        end else begin
          cmd.write  = 1'b1;
          state_next = S_DONE;
        end
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
        cmd.step  = step;
        step_next = step + STEP_W'(1);
        if (step == STEP_LAST) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.emit_ok) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ===== rtl/vfv_datapath.sv =====
// Datapath: cell map and neighbour plane memories, face evaluation, total and result register.
module vfv_datapath
  import vfv_pkg::*;
#(
  parameter int EDGE = EDGE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  vfv_cmd_t           cmd,
  output vfv_stat_t          stat,
  input  logic [1:0]         operation,
  input  logic [COORD_W-1:0] cell_x,
  input  logic [COORD_W-1:0] cell_y,
  input  logic [COORD_W-1:0] cell_z,
  input  logic [SIDE_W-1:0]  side,
  input  logic               solid,
  input  logic               cfg_we,
  input  logic [MASK_W-1:0]  cfg_data,
  input  logic               result_ready,
  output logic               result_valid,
  output logic [MASK_W-1:0]  face_mask,
  output logic [COUNT_W-1:0] face_count,
  output logic [TOTAL_W-1:0] total_faces
);

  localparam int CW          = $clog2(EDGE);
  localparam int EXT_W       = COORD_W + CW;
  localparam int CELL_AW     = 3 * CW;
  localparam int PLANE_AW    = 2 * CW + SIDE_W;
  localparam int SWEEP_W     = (CELL_AW > PLANE_AW) ? CELL_AW : PLANE_AW;
  localparam int CELL_DEPTH  = 1 << CELL_AW;
  localparam int PLANE_DEPTH = 1 << PLANE_AW;
  localparam logic [CW-1:0]    EDGE_M1  = CW'(EDGE - 1);
  localparam logic [EXT_W-1:0] EDGE_EXT = EXT_W'(EDGE);

  // Planes are indexed by the two coordinates that lie across the side's normal.
  function automatic logic [PLANE_AW-1:0] plane_addr(input logic [SIDE_W-1:0] s,
                                                     input logic [CW-1:0] x,
                                                     input logic [CW-1:0] y,
                                                     input logic [CW-1:0] z);
    logic [PLANE_AW-1:0] a;
    case (s) inside
      DIR_PZ, DIR_NZ: a = {s, x, y};
      DIR_PY, DIR_NY: a = {s, x, z};
      default:        a = {s, y, z};
    endcase
    return a;
  endfunction

  logic [MASK_W-1:0]  neighbour_present;
  logic [SWEEP_W-1:0] sweep_cnt;

  logic [1:0]        op_q;
  logic [CW-1:0]     x_q;
  logic [CW-1:0]     y_q;
  logic [CW-1:0]     z_q;
  logic [SIDE_W-1:0] side_q;
  logic              solid_q;
  logic              inside_q;

  logic [EXT_W-1:0] x_ext;
  logic [EXT_W-1:0] y_ext;
  logic [EXT_W-1:0] z_ext;

  logic [SIDE_W-1:0] dir;
  logic [CW-1:0]     nx;
  logic [CW-1:0]     ny;
  logic [CW-1:0]     nz;
  logic              in_chunk;
  logic [1:0]        src;

  logic                cell_mem [0:CELL_DEPTH-1];
  logic                plane_mem [0:PLANE_DEPTH-1];
  logic [CELL_AW-1:0]  cell_addr;
  logic [PLANE_AW-1:0] plane_sel;
  logic                cell_we;
  logic                plane_we;
  logic                cell_wd;
  logic                plane_wd;
  logic                cell_rd;
  logic                plane_rd;

  logic              pend_valid;
  logic              pend_own;
  logic [SIDE_W-1:0] pend_dir;
  logic [1:0]        pend_src;
  logic              face_open;

  logic [MASK_W-1:0]  mask;
  logic [MASK_W-1:0]  mask_next;
  logic               own_solid;
  logic               own_next;
  logic [MASK_W-1:0]  final_mask;
  logic [COUNT_W-1:0] final_count;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;

  assign x_ext = EXT_W'(cell_x);
  assign y_ext = EXT_W'(cell_y);
  assign z_ext = EXT_W'(cell_z);

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbour_present <= '0;
    end else if (cfg_we) begin
      neighbour_present <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + SWEEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= operation;
      x_q      <= x_ext[CW-1:0];
      y_q      <= y_ext[CW-1:0];
      z_q      <= z_ext[CW-1:0];
      side_q   <= side;
      solid_q  <= solid;
      inside_q <= (x_ext < EDGE_EXT) && (y_ext < EDGE_EXT) && (z_ext < EDGE_EXT);
    end
  end

  // Neighbour of the captured cell for the current scan step.
  always_comb begin
    dir      = cmd.step - STEP_W'(1);
    nx       = x_q;
    ny       = y_q;
    nz       = z_q;
    in_chunk = 1'b1;
    case (dir)
      DIR_PZ: begin
        nz       = z_q + CW'(1);
        in_chunk = (z_q != EDGE_M1);
      end
      DIR_NZ: begin
        nz       = z_q - CW'(1);
        in_chunk = (z_q != '0);
      end
      DIR_PY: begin
        ny       = y_q + CW'(1);
        in_chunk = (y_q != EDGE_M1);
      end
      DIR_NY: begin
        ny       = y_q - CW'(1);
        in_chunk = (y_q != '0);
      end
      DIR_PX: begin
        nx       = x_q + CW'(1);
        in_chunk = (x_q != EDGE_M1);
      end
      DIR_NX: begin
        nx       = x_q - CW'(1);
        in_chunk = (x_q != '0);
      end
      default: begin
        in_chunk = 1'b1;
      end
    endcase
    if (cmd.step == '0) begin
      src = SRC_CHUNK;
    end else if (in_chunk) begin
      src = SRC_CHUNK;
    end else if (neighbour_present[dir]) begin
      src = SRC_PLANE;
    end else begin
      src = SRC_NONE;
    end
  end

  always_comb begin
    if (cmd.sweep) begin
      cell_addr = sweep_cnt[CELL_AW-1:0];
      plane_sel = sweep_cnt[PLANE_AW-1:0];
    end else if (cmd.issue) begin
      cell_addr = {nx, ny, nz};
      plane_sel = plane_addr(dir, x_q, y_q, z_q);
    end else begin
      cell_addr = {x_q, y_q, z_q};
      plane_sel = plane_addr(side_q, x_q, y_q, z_q);
    end
    cell_we  = cmd.sweep || (cmd.write && (op_q == OP_LOAD_CELL) && inside_q);
    plane_we = cmd.sweep || (cmd.write && (op_q == OP_LOAD_PLANE) && inside_q &&
                             (side_q < SIDE_W'(SIDE_COUNT)));
    cell_wd  = cmd.sweep ? 1'b0 : solid_q;
    plane_wd = cmd.sweep ? 1'b0 : solid_q;
  end

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_addr] <= cell_wd;
    end
    cell_rd <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (plane_we) begin
      plane_mem[plane_sel] <= plane_wd;
    end
    plane_rd <= plane_mem[plane_sel];
  end

  // The read issued in one cycle is evaluated in the next, when its data is out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= cmd.issue;
    end
    pend_own <= (cmd.step == '0);
    pend_dir <= dir;
    pend_src <= src;
  end

  always_comb begin
    case (pend_src)
      SRC_CHUNK: face_open = !cell_rd;
      SRC_PLANE: face_open = !plane_rd;
      default:   face_open = 1'b0;
    endcase
    mask_next = mask;
    own_next  = own_solid;
    if (pend_valid) begin
      if (pend_own) begin
        own_next = cell_rd;
      end else begin
        mask_next[pend_dir] = face_open;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mask      <= '0;
      own_solid <= 1'b0;
    end else begin
      mask      <= mask_next;
      own_solid <= own_next;
    end
  end

  // A transparent cell, an outside cell and every load report no faces.
  always_comb begin
    final_mask  = own_next ? mask_next : '0;
    final_count = count_faces(final_mask);
    total_sum   = {1'b0, total} + (TOTAL_W + 1)'(final_count);
    case (op_q)
      OP_CLASSIFY:    total_next = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
      OP_CLEAR_TOTAL: total_next = '0;
      default:        total_next = total;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      result_valid <= 1'b0;
    end else if (cmd.emit) begin
      total        <= total_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      face_mask   <= final_mask;
      face_count  <= final_count;
      total_faces <= total_next;
    end
  end

  assign stat.sweep_done      = &sweep_cnt;
  assign stat.classify_inside = (op_q == OP_CLASSIFY) && inside_q;
  assign stat.emit_ok         = !result_valid || result_ready;

endmodule

// ===== rtl/voxel_face_visibility.sv =====
// Top level of the voxel face visibility block: controller, datapath and checks.
// After reset the block runs a clearing pass over every address of both memories
// and accepts no item until it ends; neighbour_present writes are taken at any time.
// A classify item passes from acceptance through a decode state and a scan state
// to the result hand-off: the cell map has one read port, so the cell itself and
// its six neighbours are read one after another in consecutive scan steps.
// Load and clear-total items go from the decode state straight to the hand-off.
// The result sits in an output register, so the next item is accepted while the
// previous result still waits to be taken; a new result is held back only while
// the previous one has not left.
module voxel_face_visibility
  import vfv_pkg::*;
#(
  parameter int CHUNK_EDGE = EDGE_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [MASK_W-1:0]  cfg_data,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [1:0]         operation,
  input  logic [COORD_W-1:0] cell_x,
  input  logic [COORD_W-1:0] cell_y,
  input  logic [COORD_W-1:0] cell_z,
  input  logic [SIDE_W-1:0]  side,
  input  logic               solid,
  output logic               result_valid,
  input  logic               result_ready,
  output logic [MASK_W-1:0]  face_mask,
  output logic [COUNT_W-1:0] face_count,
  output logic [TOTAL_W-1:0] total_faces
);

  vfv_cmd_t  cmd;
  vfv_stat_t stat;

  vfv_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  vfv_datapath #(
    .EDGE (CHUNK_EDGE)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .operation    (operation),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_z       (cell_z),
    .side         (side),
    .solid        (solid),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .face_mask    (face_mask),
    .face_count   (face_count),
    .total_faces  (total_faces)
  );

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (face_count == COUNT_W'($countones(face_mask))))
    else $error("face_count does not match face_mask");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(cmd.emit))
    else $error("result appeared without an emit command");

  a_single_command: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.sweep, cmd.capture, cmd.write, cmd.issue, cmd.emit}))
    else $error("controller issued more than one command");

endmodule
